// ===== hw/rtl/cdht_pkg.sv =====
// ----------------------------------------------------------------------------
// cdht_pkg: shared constants for the cut duplicate hash table
// Widths, defaults, status codes and the key primes.
// ----------------------------------------------------------------------------
package cdht_pkg;
  localparam int MAX_LEAVES_DEF  = 6;
  localparam int BIN_DEPTH_DEF   = 1024;
  localparam int ENTRY_DEPTH_DEF = 2048;
  localparam int LEAF_BITS_DEF   = 24;
  localparam int LEAF_SLOTS      = 6;
  localparam int STATUS_W        = 3;
  localparam int BIN_IDX_W       = 10;
  localparam int BIN_CFG_W       = 11;
  localparam int N_W             = 3;
  localparam logic [BIN_CFG_W-1:0] BIN_COUNT_RST = 11'd1021;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

  localparam logic [9:0] PRIME_COUNT = 10'd991;

  function automatic logic [9:0] key_prime(input logic [2:0] idx);
    logic [9:0] p;
    case (idx)
      3'd0: p = 10'd109;
      3'd1: p = 10'd499;
      3'd2: p = 10'd557;
      3'd3: p = 10'd619;
      3'd4: p = 10'd631;
      3'd5: p = 10'd709;
      3'd6: p = 10'd797;
      default: p = 10'd881;
    endcase
    return p;
  endfunction
endpackage

// ===== hw/rtl/cdht_in_if.sv =====
// ----------------------------------------------------------------------------
// cdht_in_if: input item channel
// Valid/ready channel carrying one cut or a clear request.
// ----------------------------------------------------------------------------
interface cdht_in_if #(parameter int LEAF_BITS = cdht_pkg::LEAF_BITS_DEF);
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [2:0]           n_leaves;
  logic                 seq_flag;
  logic                 store_flag;
  logic [LEAF_BITS-1:0] leaf_0;
  logic [LEAF_BITS-1:0] leaf_1;
  logic [LEAF_BITS-1:0] leaf_2;
  logic [LEAF_BITS-1:0] leaf_3;
  logic [LEAF_BITS-1:0] leaf_4;
  logic [LEAF_BITS-1:0] leaf_5;
  modport source (output valid, mode, n_leaves, seq_flag, store_flag,
                  leaf_0, leaf_1, leaf_2, leaf_3, leaf_4, leaf_5, input ready);
  modport sink (input valid, mode, n_leaves, seq_flag, store_flag,
                leaf_0, leaf_1, leaf_2, leaf_3, leaf_4, leaf_5, output ready);
endinterface

// ===== hw/rtl/cdht_out_if.sv =====
// ----------------------------------------------------------------------------
// cdht_out_if: result item channel
// Valid/ready channel carrying status and bin index.
// ----------------------------------------------------------------------------
interface cdht_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [9:0] bin_index;
  modport source (output valid, status, bin_index, input ready);
  modport sink (input valid, status, bin_index, output ready);
endinterface

// ===== hw/rtl/cdht_cfg_if.sv =====
// ----------------------------------------------------------------------------
// cdht_cfg_if: configuration write channel
// Valid/ready channel carrying the bin count register value.
// ----------------------------------------------------------------------------
interface cdht_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/cdht_ram.sv =====
// ----------------------------------------------------------------------------
// cdht_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module cdht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hw/rtl/cut_dedup_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// cut_dedup_hash_table_top: duplicate filter for cuts
// Chained hash table over a fixed entry pool with a single sequencer.
//
//   channel   dir   carries
//   cut_in    in    mode, n_leaves, seq_flag, store_flag, leaf_0..leaf_5
//   res_out   out   status, bin_index
//   cfg       in    bin_count
//
// A lookup hashes with one shared multiplier, one leaf per cycle, then reduces
// modulo the bin count one shift-subtract step per cycle, reads the bin head
// and walks the chain, reading each entry word and then each compared leaf. An
// insert writes the leaves and then the entry word. A clear zeroes the head of
// each recorded bin. After reset the bin heads are cleared, one per cycle,
// during which no item is taken. One item is in work at a time; its result
// moves to the output register, and the sequencer waits at the end only while
// the previous result is still unaccepted.
// ----------------------------------------------------------------------------
module cut_dedup_hash_table_top #(
  parameter int MAX_LEAVES  = cdht_pkg::MAX_LEAVES_DEF,
  parameter int BIN_DEPTH   = cdht_pkg::BIN_DEPTH_DEF,
  parameter int ENTRY_DEPTH = cdht_pkg::ENTRY_DEPTH_DEF,
  parameter int LEAF_BITS   = cdht_pkg::LEAF_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  cdht_in_if.sink  cut_in,
  cdht_out_if.source res_out,
  cdht_cfg_if.sink cfg
);
  localparam int BW  = $clog2(BIN_DEPTH);
  localparam int EW  = $clog2(ENTRY_DEPTH);
  localparam int LW  = $clog2(ENTRY_DEPTH * MAX_LEAVES);
  localparam int HW  = EW + 1;
  localparam int PW  = BW + 1;
  localparam int SW  = $clog2(MAX_LEAVES + 1);

  localparam logic [4:0] S_INIT   = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_HASH   = 5'd2;
  localparam logic [4:0] S_MOD    = 5'd3;
  localparam logic [4:0] S_HEADRD = 5'd4;
  localparam logic [4:0] S_HEADWT = 5'd5;
  localparam logic [4:0] S_ENTRD  = 5'd6;
  localparam logic [4:0] S_ENTWT  = 5'd7;
  localparam logic [4:0] S_LEAFRD = 5'd8;
  localparam logic [4:0] S_LEAFWT = 5'd9;
  localparam logic [4:0] S_MISS   = 5'd10;
  localparam logic [4:0] S_WLEAF  = 5'd11;
  localparam logic [4:0] S_WENT   = 5'd12;
  localparam logic [4:0] S_CLRRD  = 5'd13;
  localparam logic [4:0] S_CLRWT  = 5'd14;
  localparam logic [4:0] S_CLRWR  = 5'd15;
  localparam logic [4:0] S_DONE   = 5'd16;

  logic [4:0]  state;
  logic [10:0] bin_count;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [9:0]  out_bin;
  logic [2:0]  res_status;
  logic [9:0]  res_bin;

  logic [2:0]  n_r;
  logic        store_r;
  logic [LEAF_BITS-1:0] leaf_r [cdht_pkg::LEAF_SLOTS];
  logic [2:0]  hidx;
  logic [31:0] key;
  logic [31:0] rem;
  logic [5:0]  mcnt;
  logic [BW-1:0] bin;
  logic [HW-1:0] head;
  logic [HW-1:0] link;
  logic [EW:0]   steps;
  logic [EW-1:0] ent;
  logic [SW-1:0] li;
  logic [EW:0]   entry_total;
  logic [PW-1:0] place_total;
  logic [PW-1:0] pidx;
  logic [BW:0]   init_cnt;

  logic [10:0] nb;
  always_comb begin
    nb = bin_count;
    if (nb == 11'd0) nb = 11'd1;
    if ({21'd0, nb} > BIN_DEPTH) nb = 11'(BIN_DEPTH);
  end

  // RAM ports
  logic          bh_we;
  logic [BW-1:0] bh_addr;
  logic [HW-1:0] bh_wdata, bh_rdata;
  logic          en_we;
  logic [EW-1:0] en_addr;
  logic [HW+2:0] en_wdata, en_rdata;
  logic          lf_we;
  logic [LW-1:0] lf_addr;
  logic [LEAF_BITS-1:0] lf_wdata, lf_rdata;
  logic          pl_we;
  logic [BW-1:0] pl_addr;
  logic [BW-1:0] pl_wdata, pl_rdata;

  cdht_ram #(.WIDTH(HW), .DEPTH(BIN_DEPTH)) u_bin_head (
    .clk(clk), .we(bh_we), .addr(bh_addr), .wdata(bh_wdata), .rdata(bh_rdata));
  cdht_ram #(.WIDTH(HW + 3), .DEPTH(ENTRY_DEPTH)) u_entry (
    .clk(clk), .we(en_we), .addr(en_addr), .wdata(en_wdata), .rdata(en_rdata));
  cdht_ram #(.WIDTH(LEAF_BITS), .DEPTH(ENTRY_DEPTH * MAX_LEAVES)) u_leaf (
    .clk(clk), .we(lf_we), .addr(lf_addr), .wdata(lf_wdata), .rdata(lf_rdata));
  cdht_ram #(.WIDTH(BW), .DEPTH(BIN_DEPTH)) u_place (
    .clk(clk), .we(pl_we), .addr(pl_addr), .wdata(pl_wdata), .rdata(pl_rdata));

  logic [LW-1:0] ent_base;
  assign ent_base = LW'(ent) * LW'(MAX_LEAVES);

  logic [LEAF_BITS-1:0] leaf_sel;
  assign leaf_sel = leaf_r[li[2:0]];

  logic [31:0] prod;
  assign prod = 32'(leaf_r[hidx]) * 32'(cdht_pkg::key_prime(hidx));

  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  assign rem_sh  = {rem, key[31]};
  assign rem_sub = rem_sh - 33'(nb);

  logic seq_r;

  always_comb begin
    bh_we = 1'b0; bh_addr = bin; bh_wdata = head;
    en_we = 1'b0; en_addr = ent; en_wdata = {n_r, head};
    lf_we = 1'b0; lf_addr = ent_base + LW'(li); lf_wdata = leaf_sel;
    pl_we = 1'b0; pl_addr = pidx[BW-1:0]; pl_wdata = bin;
    case (state)
      S_INIT: begin
        bh_we = 1'b1; bh_addr = init_cnt[BW-1:0]; bh_wdata = '0;
      end
      S_HEADRD: bh_addr = rem[BW-1:0];
      S_CLRWR: begin
        bh_we = 1'b1; bh_addr = pl_rdata; bh_wdata = '0;
      end
      S_WLEAF: lf_we = 1'b1;
      S_WENT: begin
        en_we = 1'b1;
        bh_we = 1'b1; bh_wdata = HW'(entry_total[EW-1:0]) + HW'(1);
        pl_we = store_r && head == '0 && place_total < PW'(BIN_DEPTH);
        pl_addr = place_total[BW-1:0];
      end
      default: ;
    endcase
  end

  assign cut_in.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;
  assign res_out.valid     = out_valid;
  assign res_out.status    = out_status;
  assign res_out.bin_index = out_bin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; bin_count <= cdht_pkg::BIN_COUNT_RST; out_valid <= 1'b0;
      entry_total <= '0; place_total <= '0; init_cnt <= '0;
    end else begin
      if (cfg.valid) bin_count <= cfg.data;
      if (state == S_DONE && (!out_valid || res_out.ready)) begin
        out_valid <= 1'b1; out_status <= res_status; out_bin <= res_bin;
      end else if (res_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          init_cnt <= init_cnt + 1'b1;
          if (init_cnt == (BW+1)'(BIN_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cut_in.valid && cut_in.ready) begin
            n_r <= cut_in.n_leaves; seq_r <= cut_in.seq_flag;
            store_r <= cut_in.store_flag;
            leaf_r[0] <= cut_in.leaf_0; leaf_r[1] <= cut_in.leaf_1;
            leaf_r[2] <= cut_in.leaf_2; leaf_r[3] <= cut_in.leaf_3;
            leaf_r[4] <= cut_in.leaf_4; leaf_r[5] <= cut_in.leaf_5;
            hidx <= '0;
            key <= 32'(cut_in.n_leaves) * 32'(cdht_pkg::PRIME_COUNT);
            pidx <= '0;
            if (cut_in.mode) begin
              state <= S_CLRRD;
            end else if ({1'b0, cut_in.n_leaves} + {3'd0, cut_in.seq_flag}
                         > 4'(MAX_LEAVES)) begin
              res_status <= cdht_pkg::ST_BAD; res_bin <= '0;
              state <= S_DONE;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if ({1'b0, hidx} < {1'b0, n_r} + {3'd0, seq_r}) begin
            key  <= key + prod;
            hidx <= hidx + 1'b1;
          end else begin
            rem <= '0; mcnt <= '0; state <= S_MOD;
          end
        end
        S_MOD: begin
          key <= {key[30:0], 1'b0};
          if (!rem_sub[32]) rem <= rem_sub[31:0];
          else rem <= rem_sh[31:0];
          mcnt <= mcnt + 1'b1;
          if (mcnt == 6'd31) state <= S_HEADRD;
        end
        S_HEADRD: begin
          bin <= BW'(rem); state <= S_HEADWT;
        end
        S_HEADWT: begin
          head <= bh_rdata; link <= bh_rdata; steps <= '0;
          res_bin <= 10'(bin);
          state <= S_ENTRD;
        end
        S_ENTRD: begin
          if (link == '0 || steps == (EW+1)'(ENTRY_DEPTH)) begin
            state <= S_MISS;
          end else begin
            ent <= EW'(link - HW'(1)); li <= '0; state <= S_ENTWT;
          end
        end
        S_ENTWT: state <= S_LEAFRD;
        S_LEAFRD: begin
          // Entry word is valid now; mismatch on count skips the leaves.
          if (en_rdata[HW+2:HW] != n_r) begin
            link <= en_rdata[HW-1:0]; steps <= steps + 1'b1; state <= S_ENTRD;
          end else if (li == SW'(n_r)) begin
            res_status <= cdht_pkg::ST_FOUND; state <= S_DONE;
          end else begin
            state <= S_LEAFWT;
          end
        end
        S_LEAFWT: begin
          if (lf_rdata != leaf_sel) begin
            link <= en_rdata[HW-1:0]; steps <= steps + 1'b1; state <= S_ENTRD;
          end else begin
            li <= li + 1'b1; state <= S_LEAFRD;
          end
        end
        S_MISS: begin
          if (entry_total == (EW+1)'(ENTRY_DEPTH)) begin
            res_status <= cdht_pkg::ST_FULL; state <= S_DONE;
          end else begin
            ent <= entry_total[EW-1:0]; li <= '0; state <= S_WLEAF;
          end
        end
        S_WLEAF: begin
          li <= li + 1'b1;
          if (li + 1'b1 >= SW'(n_r)) state <= S_WENT;
        end
        S_WENT: begin
          if (pl_we) place_total <= place_total + 1'b1;
          entry_total <= entry_total + 1'b1;
          res_status <= cdht_pkg::ST_INSERTED; state <= S_DONE;
        end
        S_CLRRD: begin
          if (pidx == place_total) begin
            place_total <= '0; entry_total <= '0;
            res_status <= cdht_pkg::ST_CLEARED; res_bin <= '0; state <= S_DONE;
          end else begin
            state <= S_CLRWT;
          end
        end
        S_CLRWT: state <= S_CLRWR;
        S_CLRWR: begin
          pidx <= pidx + 1'b1; state <= S_CLRRD;
        end
        S_DONE: begin
          if (!out_valid || res_out.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/cdht_checker.sv =====
// ----------------------------------------------------------------------------
// cdht_checker: port-level assertions for the cut duplicate filter
// Watches the cut input and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module cdht_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [9:0] bin_index
);
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= cdht_pkg::ST_CLEARED)
    else $error("status code out of range");

  a_hold_bin: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(bin_index))
    else $error("bin index changed while stalled");

  a_clear_zero_bin: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == cdht_pkg::ST_CLEARED || status == cdht_pkg::ST_BAD))
      |-> bin_index == 10'd0)
    else $error("clear or bad count with nonzero bin");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(status))
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after accept");
endmodule

bind cut_dedup_hash_table_top cdht_checker u_cdht_checker (
  .clk(clk), .rst(rst),
  .in_valid(cut_in.valid), .in_ready(cut_in.ready),
  .out_valid(res_out.valid), .out_ready(res_out.ready),
  .status(res_out.status), .bin_index(res_out.bin_index)
);

// ===== test/cut_dedup_hash_table_top_tb.sv =====
// ----------------------------------------------------------------------------
// cut_dedup_hash_table_top_tb: self-checking bench for the cut duplicate filter
// Cuts, clears and bin count writes go in through the valid/ready channels.
// A local hash table model predicts each status and bin index, and the bench
// compares them in order with the results, with random idling on both sides.
// ----------------------------------------------------------------------------
module cut_dedup_hash_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBIN  = cdht_pkg::BIN_DEPTH_DEF;
  localparam int NENT  = cdht_pkg::ENTRY_DEPTH_DEF;
  localparam int WDOG  = 200000;

  typedef struct packed {
    logic                     mode;
    logic [2:0]               n_leaves;
    logic                     seq_flag;
    logic                     store_flag;
    logic [5:0][cdht_pkg::LEAF_BITS_DEF-1:0] leaf;
  } cut_item_t;

  typedef struct packed {
    logic [cdht_pkg::STATUS_W-1:0]  status;
    logic [cdht_pkg::BIN_IDX_W-1:0] bin_index;
  } cut_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cdht_in_if  cut_in ();
  cdht_out_if res_out ();
  cdht_cfg_if cfg ();

  cut_dedup_hash_table_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .cut_in  (cut_in.sink),
    .res_out (res_out.source),
    .cfg     (cfg.sink)
  );

  // Table model state.
  logic [11:0]                        head_tab [NBIN];
  logic [cdht_pkg::LEAF_BITS_DEF-1:0] ent_leaf [NENT][6];
  logic [2:0]                         ent_cnt  [NENT];
  logic [11:0]                        ent_next [NENT];
  logic [9:0]                         placed   [NBIN];
  int unsigned                        ent_used;
  int unsigned                        placed_used;
  logic [10:0]                        bins_cfg;

  cut_item_t pending_cuts [$];
  cut_res_t  expected_res [$];
  int        fail_cnt = 0;
  int        idle_pct = 25;
  int        quiet_cnt = 0;

  function automatic int unsigned key_weight(input int idx);
    case (idx)
      0: return 109;
      1: return 499;
      2: return 557;
      3: return 619;
      4: return 631;
      5: return 709;
      default: return 797;
    endcase
  endfunction

  function automatic cut_res_t lookup_insert(input cut_item_t c);
    cut_res_t    r;
    int unsigned nb, key, link, steps, e, tot;
    bit          same;
    tot = 32'(c.n_leaves) + 32'(c.seq_flag);
    if (c.mode) begin
      for (int i = 0; i < placed_used; i++) head_tab[placed[i]] = '0;
      placed_used = 0;
      ent_used = 0;
      r.status = cdht_pkg::ST_CLEARED;
      r.bin_index = '0;
      return r;
    end
    if (c.n_leaves > cdht_pkg::MAX_LEAVES_DEF || tot > cdht_pkg::MAX_LEAVES_DEF) begin
      r.status = cdht_pkg::ST_BAD;
      r.bin_index = '0;
      return r;
    end
    nb = 32'(bins_cfg);
    if (nb == 0) nb = 1;
    if (nb > NBIN) nb = NBIN;
    key = 32'(c.n_leaves) * 991;
    for (int i = 0; i < tot; i++) key += key_weight(i) * 32'(c.leaf[i]);
    key = key % nb;
    r.bin_index = key[9:0];
    link = 32'(head_tab[key]);
    for (steps = 0; link != 0 && steps < NENT; steps++) begin
      e = (link - 1) % NENT;
      if (ent_cnt[e] == c.n_leaves) begin
        same = 1'b1;
        for (int i = 0; i < c.n_leaves; i++)
          if (ent_leaf[e][i] != c.leaf[i]) same = 1'b0;
        if (same) begin
          r.status = cdht_pkg::ST_FOUND;
          return r;
        end
      end
      link = 32'(ent_next[e]);
    end
    if (ent_used >= NENT) begin
      r.status = cdht_pkg::ST_FULL;
      return r;
    end
    if (c.store_flag && head_tab[key] == 0 && placed_used < NBIN) begin
      placed[placed_used] = key[9:0];
      placed_used++;
    end
    e = ent_used;
    for (int i = 0; i < c.n_leaves; i++) ent_leaf[e][i] = c.leaf[i];
    ent_cnt[e] = c.n_leaves;
    ent_next[e] = head_tab[key];
    head_tab[key] = 12'(e + 1);
    ent_used++;
    r.status = cdht_pkg::ST_INSERTED;
    return r;
  endfunction

  function automatic cut_item_t make_cut(input int unsigned n, input bit sq, input bit st,
                                         input int unsigned leaf_max);
    cut_item_t c;
    c.mode = 1'b0;
    c.n_leaves = 3'(n);
    c.seq_flag = sq;
    c.store_flag = st;
    for (int i = 0; i < 6; i++)
      c.leaf[i] = cdht_pkg::LEAF_BITS_DEF'($urandom_range(leaf_max, 0));
    return c;
  endfunction

  function automatic cut_item_t clear_cut();
    cut_item_t c;
    c = '0;
    c.mode = 1'b1;
    c.n_leaves = 3'($urandom);
    for (int i = 0; i < 6; i++) c.leaf[i] = cdht_pkg::LEAF_BITS_DEF'($urandom);
    return c;
  endfunction

  initial begin
    forever #2 clk = ~clk;
  end

  // Input driver.
  always @(posedge clk) begin
    if (rst) begin
      cut_in.valid <= 1'b0;
    end else if (!cut_in.valid || cut_in.ready) begin
      if (pending_cuts.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
        cut_in.valid <= 1'b1;
        {cut_in.mode, cut_in.n_leaves, cut_in.seq_flag, cut_in.store_flag} <=
          {pending_cuts[0].mode, pending_cuts[0].n_leaves, pending_cuts[0].seq_flag,
           pending_cuts[0].store_flag};
        cut_in.leaf_0 <= pending_cuts[0].leaf[0];
        cut_in.leaf_1 <= pending_cuts[0].leaf[1];
        cut_in.leaf_2 <= pending_cuts[0].leaf[2];
        cut_in.leaf_3 <= pending_cuts[0].leaf[3];
        cut_in.leaf_4 <= pending_cuts[0].leaf[4];
        cut_in.leaf_5 <= pending_cuts[0].leaf[5];
        expected_res.push_back(lookup_insert(pending_cuts.pop_front()));
      end else begin
        cut_in.valid <= 1'b0;
      end
    end
  end

  // Result monitor and watchdog.
  always @(posedge clk) begin
    if (rst) begin
      res_out.ready <= 1'b0;
      quiet_cnt <= 0;
    end else begin
      res_out.ready <= ($urandom_range(99, 0) >= idle_pct);
      if ((cut_in.valid && cut_in.ready) || (res_out.valid && res_out.ready) ||
          (cfg.valid && cfg.ready))
        quiet_cnt <= 0;
      else
        quiet_cnt <= quiet_cnt + 1;
      if (res_out.valid && res_out.ready) begin
        if (expected_res.size() == 0) begin
          $error("result with none expected: status %0d bin_index %0d",
                 res_out.status, res_out.bin_index);
          fail_cnt++;
        end else begin
          if (res_out.status !== expected_res[0].status) begin
            $error("status: expected %0d, actual %0d", expected_res[0].status, res_out.status);
            fail_cnt++;
          end
          if (res_out.bin_index !== expected_res[0].bin_index) begin
            $error("bin_index: expected %0d, actual %0d", expected_res[0].bin_index,
                   res_out.bin_index);
            fail_cnt++;
          end
          void'(expected_res.pop_front());
        end
      end
      if (quiet_cnt > WDOG) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic drain();
    wait (pending_cuts.size() == 0);
    @(posedge clk);
    while (cut_in.valid || expected_res.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_bins(input logic [10:0] v);
    drain();
    cfg.data <= v;
    cfg.valid <= 1'b1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    bins_cfg = v;
  endtask

  task automatic run_phase(input int cnt);
    cut_item_t hist [$];
    cut_item_t c;
    int unsigned r;
    for (int k = 0; k < cnt; k++) begin
      r = $urandom_range(99, 0);
      if (r < 4) c = clear_cut();
      else if (r < 8) c = make_cut($urandom_range(7, 0), 1'($urandom), 1'($urandom),
                                   24'hFFFFFF);
      else if (r < 35 && hist.size() > 0) begin
        c = hist[$urandom_range(hist.size() - 1, 0)];
        c.store_flag = 1'($urandom);
      end else begin
        c = make_cut($urandom_range(6, 0), 1'b0, 1'($urandom),
                     ($urandom & 1) ? 24'hFFFFFF : 15);
        if (c.n_leaves < 6) c.seq_flag = 1'($urandom);
      end
      if (!c.mode) hist.push_back(c);
      pending_cuts.push_back(c);
    end
  endtask

  initial begin
    cut_item_t c;
    bins_cfg = cdht_pkg::BIN_COUNT_RST;
    ent_used = 0;
    placed_used = 0;
    foreach (head_tab[i]) head_tab[i] = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    cut_in.valid = 1'b0;
    cut_in.mode = 1'b0;
    cut_in.n_leaves = '0;
    cut_in.seq_flag = 1'b0;
    cut_in.store_flag = 1'b0;
    cut_in.leaf_0 = '0;
    cut_in.leaf_1 = '0;
    cut_in.leaf_2 = '0;
    cut_in.leaf_3 = '0;
    cut_in.leaf_4 = '0;
    cut_in.leaf_5 = '0;
    res_out.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed cuts at reset bin count.
    for (int n = 0; n <= 7; n++) begin
      c = make_cut(n, n[0], 1'b1, 24'hFFFFFF);
      pending_cuts.push_back(c);
      pending_cuts.push_back(c);
    end
    c = make_cut(6, 1'b0, 1'b1, 0);
    pending_cuts.push_back(c);
    c.leaf = '1;
    pending_cuts.push_back(c);
    c = make_cut(5, 1'b1, 1'b0, 0);
    c.leaf[5] = 24'hFFFFFF;
    pending_cuts.push_back(c);
    pending_cuts.push_back(clear_cut());
    pending_cuts.push_back(c);
    drain();

    write_bins(11'd0);
    run_phase(30);
    write_bins(11'd2047);
    run_phase(60);
    idle_pct = 0;
    write_bins(11'd1024);
    run_phase(60);
    idle_pct = 25;
    write_bins(11'd7);
    run_phase(60);
    write_bins(11'd1);
    run_phase(30);
    write_bins(11'd1021);
    run_phase(100);
    write_bins(11'd13);
    run_phase(60);
    drain();

    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/cdht_pkg.sv
hw/rtl/cdht_in_if.sv
hw/rtl/cdht_out_if.sv
hw/rtl/cdht_cfg_if.sv
hw/rtl/cdht_ram.sv
hw/rtl/cut_dedup_hash_table_top.sv
hw/rtl/cdht_checker.sv
test/cut_dedup_hash_table_top_tb.sv
